FILE: hw/rtl/fpbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpbc_pkg: shared constants and types of the frustum point/box cull block
// widths of the fixed-point coordinates, plane coefficients and exact sums
// ----------------------------------------------------------------------------
package fpbc_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    localparam int NUM_PAIRS   = 8;
    localparam int PAIR_W      = 64;
    localparam int HALF_W      = 32;
    localparam int NUM_ENTRIES = 2 * NUM_PAIRS;
    localparam int IDX_W       = $clog2(NUM_PAIRS);
    localparam int ADDR_W      = IDX_W + 3;

    localparam int NUM_PLANES  = 6;
    localparam int NUM_STAGES  = 5;

    // plane coefficient is a sum or difference of two entries
    localparam int CO_W    = COORD_WIDTH + 1;
    localparam int PROD_W  = CO_W + COORD_WIDTH;
    localparam int DTERM_W = CO_W + FRAC_BITS;
    localparam int SUM_W   = ((PROD_W > DTERM_W) ? PROD_W : DTERM_W) + 2;

    localparam logic OP_POINT = 1'b0;
    localparam logic OP_BOX   = 1'b1;

    typedef logic signed [COORD_WIDTH-1:0] fpbc_coord_t;
    typedef fpbc_coord_t [2:0]             fpbc_vec_t;
    typedef logic signed [CO_W-1:0]        fpbc_coef_t;
    // index 0..2 normal components, index 3 offset
    typedef fpbc_coef_t [3:0]              fpbc_plane_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] valid;
    } fpbc_pipe_t;

endpackage

FILE: hw/rtl/fpbc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpbc_cfg: matrix registers and plane formation
// apb register file for the 4x4 matrix, six planes built by row differences and sums
// ----------------------------------------------------------------------------
module fpbc_cfg
    import fpbc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [PAIR_W-1:0]   pwdata,
    output logic [PAIR_W-1:0]   prdata,
    output logic                pready,
    output fpbc_plane_t         planes [NUM_PLANES]
);

    logic [PAIR_W-1:0]      matrix_pair_reg [NUM_PAIRS];
    logic [COORD_WIDTH-1:0] ent [NUM_ENTRIES];
    fpbc_plane_t            plane_next [NUM_PLANES];
    fpbc_plane_t            plane_reg  [NUM_PLANES];
    logic [IDX_W-1:0]       idx;

    assign idx    = paddr[ADDR_W-1:3];
    assign pready = 1'b1;
    assign prdata = matrix_pair_reg[idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_PAIRS; k++)
            begin
                matrix_pair_reg[k] <= '0;
            end
        end
        else if (psel && penable && pwrite && pready)
        begin
            matrix_pair_reg[idx] <= pwdata;
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_PAIRS; k++)
        begin
            ent[2*k]   = matrix_pair_reg[k][COORD_WIDTH-1:0];
            ent[2*k+1] = matrix_pair_reg[k][HALF_W+COORD_WIDTH-1:HALF_W];
        end
    end

    // left/right, bottom/top, near/far = row3 +/- row axis
    always_comb
    begin
        fpbc_coef_t w;
        fpbc_coef_t e;
        for (int a = 0; a < 3; a++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                w = {ent[3+4*j][COORD_WIDTH-1], ent[3+4*j]};
                e = {ent[a+4*j][COORD_WIDTH-1], ent[a+4*j]};
                plane_next[2*a][j]   = w + e;
                plane_next[2*a+1][j] = w - e;
            end
        end
    end

    // payload only, registered, follows the matrix in the next cycle
    always_ff @(posedge clk)
    begin
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            plane_reg[p] <= plane_next[p];
        end
    end

    assign planes = plane_reg;

endmodule

FILE: hw/rtl/fpbc_pipe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpbc_pipe_ctrl: valid chain and stage load enables
// each stage loads when empty or when the stage after it moves
// ----------------------------------------------------------------------------
module fpbc_pipe_ctrl
    import fpbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       out_stall,
    output logic       in_stall,
    output fpbc_pipe_t pipe
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] ready;

    always_comb
    begin
        ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !out_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    always_comb
    begin
        if (ready[0])
        begin
            valid_next[0] = in_valid;
        end
        else
        begin
            valid_next[0] = valid_reg[0];
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (ready[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
            else
            begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall   = !ready[0];
    assign pipe.load  = ready;
    assign pipe.valid = valid_reg;

endmodule

FILE: hw/rtl/fpbc_plane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpbc_plane: exact signed distance test against one plane
// p-vertex select and multiply, two partial sums, final add and sign
// ----------------------------------------------------------------------------
module fpbc_plane
    import fpbc_pkg::*;
(
    input  logic        clk,
    input  fpbc_pipe_t  pipe,
    input  fpbc_plane_t plane,
    input  logic        operation,
    input  fpbc_vec_t   min_c,
    input  fpbc_vec_t   max_c,
    output logic        ok
);

    logic signed [PROD_W-1:0] prod_next [3];
    logic signed [PROD_W-1:0] prod_reg  [3];
    logic signed [SUM_W-1:0]  dterm_next;
    logic signed [SUM_W-1:0]  dterm_reg;
    logic signed [SUM_W-1:0]  sum_a_next;
    logic signed [SUM_W-1:0]  sum_b_next;
    logic signed [SUM_W-1:0]  sum_a_reg;
    logic signed [SUM_W-1:0]  sum_b_reg;
    logic signed [SUM_W-1:0]  total;
    logic                     ok_reg;

    // p-vertex: for a box, max where the normal component is not negative, else min; a point uses min
    always_comb
    begin
        fpbc_coef_t  co;
        fpbc_coord_t pv;
        for (int j = 0; j < 3; j++)
        begin
            co = plane[j];
            if (operation == OP_BOX && !co[CO_W-1])
            begin
                pv = max_c[j];
            end
            else
            begin
                pv = min_c[j];
            end
            prod_next[j] = co * pv;
        end
        dterm_next = SUM_W'(plane[3]) <<< FRAC_BITS;
    end

    assign sum_a_next = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]);
    assign sum_b_next = SUM_W'(prod_reg[2]) + dterm_reg;
    assign total      = sum_a_reg + sum_b_reg;

    always_ff @(posedge clk)
    begin
        if (pipe.load[1])
        begin
            prod_reg  <= prod_next;
            dterm_reg <= dterm_next;
        end
        if (pipe.load[2])
        begin
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
        end
        if (pipe.load[3])
        begin
            ok_reg <= !total[SUM_W-1];
        end
    end

    assign ok = ok_reg;

endmodule

FILE: hw/rtl/frustum_point_box_cull.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_point_box_cull: point / axis-aligned box frustum test
// six gribb-hartmann planes from a view-projection matrix, exact fixed point
// ----------------------------------------------------------------------------
// usage
//   program the 4x4 matrix (signed q16.16, two entries per 64-bit register)
//   over apb while no transaction is in flight; register k at byte 8*k
//   send a point (operation 0, min fields) or a box (operation 1) on the
//   input channel; a transaction completes when in_valid is high and
//   in_stall is low
//   each item returns one inside_res bit on the output channel, in order
// stages and throughput
//   five register stages: input register, multiply, partial sums, plane
//   sign and output register; out_valid rises once the item reaches the
//   output register
//   one item per cycle sustained while out_stall is low; 18 multipliers
//   (6 planes x 3 axes) run in parallel in the multiply stage
// reset
//   clears the matrix (every plane then has zero distance, so everything
//   reads inside) and empties the pipeline
// stall
//   when out_stall holds the result, stages behind it keep filling; in_stall
//   rises only once all five stages hold an item
// ----------------------------------------------------------------------------
module frustum_point_box_cull
    import fpbc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [PAIR_W-1:0]  pwdata,
    output logic [PAIR_W-1:0]  prdata,
    output logic               pready,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               operation,
    input  logic signed [31:0] min_x,
    input  logic signed [31:0] min_y,
    input  logic signed [31:0] min_z,
    input  logic signed [31:0] max_x,
    input  logic signed [31:0] max_y,
    input  logic signed [31:0] max_z,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic               inside_res
);

    fpbc_plane_t             planes [NUM_PLANES];
    fpbc_pipe_t              pipe;
    logic                    op_reg;
    fpbc_vec_t               min_reg;
    fpbc_vec_t               max_reg;
    logic [NUM_PLANES-1:0]   plane_ok;
    logic                    inside_reg;

    // matrix registers and plane coefficients
    fpbc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .planes  (planes)
    );

    // valid bits and per-stage load enables
    fpbc_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .pipe      (pipe)
    );

    // stage 1: input register, coordinates taken at full width
    always_ff @(posedge clk)
    begin
        if (pipe.load[0])
        begin
            op_reg     <= operation;
            min_reg[0] <= min_x[COORD_WIDTH-1:0];
            min_reg[1] <= min_y[COORD_WIDTH-1:0];
            min_reg[2] <= min_z[COORD_WIDTH-1:0];
            max_reg[0] <= max_x[COORD_WIDTH-1:0];
            max_reg[1] <= max_y[COORD_WIDTH-1:0];
            max_reg[2] <= max_z[COORD_WIDTH-1:0];
        end
    end

    // stages 2 to 4: one distance test per plane
    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_plane
        fpbc_plane u_plane (
            .clk       (clk),
            .pipe      (pipe),
            .plane     (planes[p]),
            .operation (op_reg),
            .min_c     (min_reg),
            .max_c     (max_reg),
            .ok        (plane_ok[p])
        );
    end

    // stage 5: output register, inside when no plane is negative
    always_ff @(posedge clk)
    begin
        if (pipe.load[NUM_STAGES-1])
        begin
            inside_reg <= &plane_ok;
        end
    end

    assign out_valid  = pipe.valid[NUM_STAGES-1];
    assign inside_res = inside_reg;

`ifndef ASSERT_OFF
    // an empty output stage never pushes back on the input
    a_no_stall_when_drained : assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output stage empty");

    // an accepted item always lands in the first stage
    a_accept_fills_stage1 : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> pipe.valid[0])
        else $error("accepted item lost at input register");

    // an item in the plane stage moves to the output when not held
    a_advance_to_output : assert property (@(posedge clk) disable iff (!rst_n)
        (pipe.valid[NUM_STAGES-2] && !out_stall) |=> out_valid)
        else $error("item lost before output register");
`endif

endmodule
